// File: sv/snlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlt_pkg: shared types for the sensor node loss table
// Beat payloads, command codes, controller state and control/status structs.
// ----------------------------------------------------------------------------
package snlt_pkg;

   localparam int KeyBits   = 64;
   localparam int TimeBits  = 63;
   localparam int WordBits  = 32;
   localparam int CountBits = 5;

   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_TOTALS = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [KeyBits-1:0]     node_key;
      logic [3:0]             read_slot;
      logic [WordBits-1:0]    temp_bits;
      logic                   temp_ok;
      logic [WordBits-1:0]    node_seq_in;
      logic [WordBits-1:0]    node_uptime_in;
      logic [TimeBits-1:0]    now_time;
      logic                   by_event;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [CountBits-1:0]   slot_or_count;
      logic                   stale;
      logic [WordBits-1:0]    temp_out;
      logic                   temp_ok_out;
      logic [WordBits-1:0]    last_seq_out;
      logic [WordBits-1:0]    uptime_out;
      logic [TimeBits-1:0]    heard_time_out;
      logic [WordBits-1:0]    rx_out;
      logic [WordBits-1:0]    loss_out;
      logic [WordBits-1:0]    event_out;
      logic [WordBits-1:0]    timer_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_READ,
      ST_RESPOND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request beat
      logic scan_clr;   // reset scan pointer and results
      logic scan_step;  // compare one entry, advance
      logic reject;     // count a reject, zero response
      logic update;     // write entry and build report response
      logic read_ent;   // build read response
      logic totals;     // build totals response
      logic clear;      // clear table
      logic respond;    // drive strobe
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    key_zero;
      logic    scan_done;
      logic    hit;
      logic    have_free;
   } sts_type;

endpackage

// File: sv/snlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlt_ctrl: command sequencer
// Walks a command through decide, scan, update or read and the response beat.
// ----------------------------------------------------------------------------
module snlt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  snlt_pkg::sts_type sts,
   output snlt_pkg::ctl_type ctl
);
   import snlt_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load     = 1'b1;
               ctl.scan_clr = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (sts.cmd)
               CMD_REPORT: begin
                  if (sts.key_zero) begin
                     ctl.reject = 1'b1;
                     state_in   = ST_RESPOND;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               CMD_READ: begin
                  ctl.read_ent = 1'b1;
                  state_in     = ST_READ;
               end
               CMD_TOTALS: begin
                  ctl.totals = 1'b1;
                  state_in   = ST_RESPOND;
               end
               default: begin
                  ctl.clear = 1'b1;
                  state_in  = ST_RESPOND;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_UPDATE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            if (sts.hit || sts.have_free) begin
               ctl.update = 1'b1;
            end else begin
               ctl.reject = 1'b1;
            end
            state_in = ST_RESPOND;
         end
         ST_READ: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            ctl.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/snlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snlt_datapath: entry table, scan pointer, totals and response register
// Entries live in flip-flops with per-entry used bits; the scan compares one
// entry per cycle. Fields of unused entries read as zero.
// ----------------------------------------------------------------------------
module snlt_datapath #(
   parameter int TABLE_ENTRIES   = 16,
   parameter int KEY_CHARS       = 8,
   parameter int MISSES_TO_STALE = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  snlt_pkg::req_type req,
   input  logic [31:0]       interval,
   input  snlt_pkg::ctl_type ctl,
   output snlt_pkg::sts_type sts,
   output snlt_pkg::rsp_type rsp
);
   import snlt_pkg::*;

   localparam int IdxBits  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PtrBits  = $clog2(TABLE_ENTRIES + 1);
   localparam int MulBits  = $clog2(MISSES_TO_STALE + 1);
   localparam int LimBits  = WordBits + MulBits;
   localparam logic [KeyBits-1:0] KeyMask =
      (KEY_CHARS >= 8) ? {KeyBits{1'b1}} :
      KeyBits'((65'd1 << (8 * KEY_CHARS)) - 65'd1);

   typedef struct packed {
      logic [KeyBits-1:0]  key;
      logic [WordBits-1:0] temp;
      logic                temp_ok;
      logic [WordBits-1:0] seq;
      logic [WordBits-1:0] uptime;
      logic [TimeBits-1:0] heard;
      logic [WordBits-1:0] rx;
      logic [WordBits-1:0] loss;
      logic [WordBits-1:0] events;
      logic [WordBits-1:0] timers;
   } entry_type;

   logic [TABLE_ENTRIES-1:0] used_ff;
   entry_type                ent_ff [TABLE_ENTRIES];
   req_type                  req_ff;
   logic [PtrBits-1:0]       ptr_ff;
   logic                     hit_ff, free_ff;
   logic [IdxBits-1:0]       hit_idx_ff, free_idx_ff;
   logic [CountBits-1:0]     claimed_ff;
   logic [WordBits-1:0]      received_ff, rejected_ff;
   logic [LimBits-1:0]       limit_ff;
   rsp_type                  rsp_ff;

   logic [KeyBits-1:0]  mkey;
   logic [IdxBits-1:0]  ptr_idx, tgt, rd_idx;
   logic                rd_valid, rd_used;
   entry_type           cur, upd, rd_ent;
   logic [WordBits-1:0] seq_next;
   logic                stale_rd;
   logic [TimeBits-1:0] age;
   rsp_type             rsp_in;

   assign mkey    = req_ff.node_key & KeyMask;
   assign ptr_idx = ptr_ff[IdxBits-1:0];
   assign tgt     = hit_ff ? hit_idx_ff : free_idx_ff;

   assign sts.cmd       = req_ff.cmd;
   assign sts.key_zero  = (mkey == '0);
   assign sts.scan_done = hit_ff || (ptr_ff == PtrBits'(TABLE_ENTRIES));
   assign sts.hit       = hit_ff;
   assign sts.have_free = free_ff;
   assign rsp           = rsp_ff;

   // current value of target entry, zero when unused
   always_comb begin
      cur = used_ff[tgt] ? ent_ff[tgt] : '0;
      seq_next = cur.seq + 32'd1;
      upd = cur;
      upd.key = mkey;
      if ((cur.rx != '0) && (req_ff.node_seq_in > seq_next)) begin
         upd.loss = cur.loss + (req_ff.node_seq_in - seq_next);
      end
      upd.temp    = req_ff.temp_bits;
      upd.temp_ok = req_ff.temp_ok;
      upd.seq     = req_ff.node_seq_in;
      upd.uptime  = req_ff.node_uptime_in;
      upd.heard   = req_ff.now_time;
      upd.rx      = cur.rx + 32'd1;
      if (req_ff.by_event) begin
         upd.events = cur.events + 32'd1;
      end else begin
         upd.timers = cur.timers + 32'd1;
      end
   end

   // read-side entry and staleness (limit precomputed at load)
   always_comb begin
      rd_valid = ({4'd0, req_ff.read_slot} < 8'(TABLE_ENTRIES)) || (TABLE_ENTRIES > 15);
      rd_idx   = IdxBits'(req_ff.read_slot);
      rd_used  = rd_valid && used_ff[rd_idx];
      rd_ent   = rd_used ? ent_ff[rd_idx] : '0;
      age      = req_ff.now_time - rd_ent.heard;
      if (!rd_used || rd_ent.rx == '0) begin
         stale_rd = 1'b1;
      end else if (req_ff.now_time <= rd_ent.heard) begin
         stale_rd = 1'b0;
      end else begin
         stale_rd = {1'b0, age} > 64'(limit_ff);
      end
   end

   // response beat for the command in flight
   always_comb begin
      rsp_in = '0;
      if (ctl.totals) begin
         rsp_in.ok            = 1'b1;
         rsp_in.slot_or_count = claimed_ff;
         rsp_in.rx_out        = received_ff;
         rsp_in.loss_out      = rejected_ff;
      end
      if (ctl.clear) begin
         rsp_in.ok = 1'b1;
      end
      if (ctl.update) begin
         rsp_in.ok             = 1'b1;
         rsp_in.slot_or_count  = CountBits'(tgt);
         rsp_in.stale          = (upd.rx == '0);
         rsp_in.temp_out       = upd.temp;
         rsp_in.temp_ok_out    = upd.temp_ok;
         rsp_in.last_seq_out   = upd.seq;
         rsp_in.uptime_out     = upd.uptime;
         rsp_in.heard_time_out = upd.heard;
         rsp_in.rx_out         = upd.rx;
         rsp_in.loss_out       = upd.loss;
         rsp_in.event_out      = upd.events;
         rsp_in.timer_out      = upd.timers;
      end
      if (ctl.read_ent) begin
         rsp_in.ok             = rd_used;
         rsp_in.slot_or_count  = {1'b0, req_ff.read_slot};
         rsp_in.stale          = stale_rd;
         rsp_in.temp_out       = rd_ent.temp;
         rsp_in.temp_ok_out    = rd_ent.temp_ok;
         rsp_in.last_seq_out   = rd_ent.seq;
         rsp_in.uptime_out     = rd_ent.uptime;
         rsp_in.heard_time_out = rd_ent.heard;
         rsp_in.rx_out         = rd_ent.rx;
         rsp_in.loss_out       = rd_ent.loss;
         rsp_in.event_out      = rd_ent.events;
         rsp_in.timer_out      = rd_ent.timers;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         claimed_ff  <= '0;
         received_ff <= '0;
         rejected_ff <= '0;
         ptr_ff      <= '0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         if (ctl.scan_clr) begin
            ptr_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end
         if (ctl.scan_step) begin
            if (used_ff[ptr_idx] && ent_ff[ptr_idx].key == mkey) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= ptr_idx;
            end else if (!used_ff[ptr_idx] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= ptr_idx;
            end
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (ctl.reject) begin
            rejected_ff <= rejected_ff + 32'd1;
         end
         if (ctl.update) begin
            used_ff[tgt] <= 1'b1;
            received_ff  <= received_ff + 32'd1;
            if (!hit_ff) begin
               claimed_ff <= claimed_ff + 1'b1;
            end
         end
         if (ctl.clear) begin
            used_ff     <= '0;
            claimed_ff  <= '0;
            received_ff <= '0;
            rejected_ff <= '0;
         end
      end
   end

   // payload registers; stale limit is the full-width product
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req;
         limit_ff <= LimBits'(interval) * LimBits'(MISSES_TO_STALE);
      end
      if (ctl.update) begin
         ent_ff[tgt] <= upd;
      end
      if (ctl.reject || ctl.totals || ctl.clear || ctl.update || ctl.read_ent) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: sv/sensor_node_loss_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_node_loss_table: per-node reception and loss table
//
//   channel | ports                        | beat marker
//   --------+------------------------------+---------------------
//   request | start, busy, req_beat        | start && !busy
//   result  | rsp_valid, rsp_beat          | rsp_valid, no stall
//   config  | csr_we, csr_wdata            | csr_we
//
// A report scans the table, one entry compared per cycle and stopping at a
// match; a read, totals, clear and an empty-id reject do not scan.
// Synchronous reset clears the table, totals and interval.
// The result beat lasts one cycle; busy drops the cycle after it.
// ----------------------------------------------------------------------------
module sensor_node_loss_table #(
   parameter int TABLE_ENTRIES   = 16,
   parameter int KEY_CHARS       = 8,
   parameter int MISSES_TO_STALE = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  snlt_pkg::req_type req_beat,
   output logic              rsp_valid,
   output snlt_pkg::rsp_type rsp_beat,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);
   import snlt_pkg::*;

   ctl_type     ctl;
   sts_type     sts;
   logic [31:0] interval_ff;

   // interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (csr_we) begin
         interval_ff <= csr_wdata;
      end
   end

   assign rsp_valid = ctl.respond;

   snlt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   snlt_datapath #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .KEY_CHARS       (KEY_CHARS),
      .MISSES_TO_STALE (MISSES_TO_STALE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req      (req_beat),
      .interval (interval_ff),
      .ctl      (ctl),
      .sts      (sts),
      .rsp      (rsp_beat)
   );

endmodule
